[design/rgbadp_pkg.sv]
// shared types and constants for the rgba delta decorrelation prefilter
// no dependencies; used by every module of the block
`default_nettype none

package rgbadp_pkg;

  // pixel geometry
  localparam int CH_W  = 8;
  localparam int NCH   = 4;
  localparam int PIX_W = CH_W * NCH;

  // configuration register widths
  localparam int IMG_W_W = 13;
  localparam int IMG_H_W = 16;

  // apb-style port geometry
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // register select, taken from address bit 2
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // position flags of one pixel, from the position tracker to the filter stage
  typedef struct packed {
    logic first_col;
    logic first_row;
    logic eol;
    logic eob;
    logic eoi;
  } pos_info_t;

endpackage

`default_nettype wire

[design/rgbadp_line_mem.sv]
// line memory holding the previous row of pixels, one read and one write port
// read data registered, with same-entry bypass; uses rgbadp_pkg
`default_nettype none

module rgbadp_line_mem #(
  parameter int MAX_WIDTH = 4096,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_addr,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [rgbadp_pkg::PIX_W-1:0] wr_data,
  output logic      [rgbadp_pkg::PIX_W-1:0] rd_data
);

  logic [rgbadp_pkg::PIX_W-1:0] mem [MAX_WIDTH];
  logic [rgbadp_pkg::PIX_W-1:0] rd_q_r;
  logic [rgbadp_pkg::PIX_W-1:0] byp_data_r;
  logic                         byp_sel_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, holds its data while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // a read that meets a write of the same entry takes the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_sel_r <= 1'b0;
    end else if (rd_en) begin
      byp_sel_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_sel_r ? byp_data_r : rd_q_r;

endmodule

`default_nettype wire

[design/rgbadp_pos.sv]
// position tracker: column, row and block counters, line memory address, end flags
// uses rgbadp_pkg for widths and the pos_info_t struct
`default_nettype none

module rgbadp_pos #(
  parameter int MAX_WIDTH  = 4096,
  parameter int BLOCK_ROWS = 4,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           accept,
  input  wire logic                           frame_start,
  input  wire logic [rgbadp_pkg::IMG_W_W-1:0] image_width,
  input  wire logic [rgbadp_pkg::IMG_H_W-1:0] image_height,
  output logic      [AW-1:0]                  rd_addr,
  output rgbadp_pkg::pos_info_t               info
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int BW = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
  localparam int HW = rgbadp_pkg::IMG_H_W;

  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [HW-1:0] row_cnt_r, row_cnt_nxt;
  logic [BW-1:0] blk_cnt_r, blk_cnt_nxt;

  logic [31:0]   iw_ext;
  logic [CW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [CW-1:0] cc_base, cc;
  logic [HW-1:0] rc_base;
  logic [BW-1:0] blk_base;
  logic          eol, eoi, eob, row_end, blk_end;

  // effective image size: zero acts as one, width capped at the line length
  assign iw_ext = 32'(image_width);

  always_comb begin
    if (image_width == '0) begin
      eff_w = CW'(1);
    end else if (iw_ext > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(iw_ext);
    end
  end

  assign eff_h = (image_height == '0) ? HW'(1) : image_height;

  // frame start restarts the position before the pixel is taken
  assign cc_base  = frame_start ? '0 : col_cnt_r;
  assign rc_base  = frame_start ? '0 : row_cnt_r;
  assign blk_base = frame_start ? '0 : blk_cnt_r;

  // a column beyond a shrunk width ends its row here
  assign cc = (cc_base >= eff_w) ? (eff_w - CW'(1)) : cc_base;

  // end flags
  assign eol     = (cc == (eff_w - CW'(1)));
  assign row_end = ({1'b0, rc_base} + (HW+1)'(1)) >= {1'b0, eff_h};
  assign blk_end = (blk_base == BW'(BLOCK_ROWS - 1));
  assign eoi     = eol && row_end;
  assign eob     = eol && (eoi || blk_end);

  assign rd_addr        = cc[AW-1:0];
  assign info.first_col = (cc == '0);
  assign info.first_row = (rc_base == '0);
  assign info.eol       = eol;
  assign info.eob       = eob;
  assign info.eoi       = eoi;

  // counter advance
  always_comb begin
    col_cnt_nxt = CW'(cc + CW'(1));
    row_cnt_nxt = rc_base;
    blk_cnt_nxt = blk_base;
    if (eol) begin
      col_cnt_nxt = '0;
      if (eoi) begin
        row_cnt_nxt = '0;
        blk_cnt_nxt = '0;
      end else begin
        row_cnt_nxt = rc_base + HW'(1);
        blk_cnt_nxt = blk_end ? '0 : (blk_base + BW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      blk_cnt_r <= '0;
    end else if (accept) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      blk_cnt_r <= blk_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[design/rgbadp_filter.sv]
// per-channel vertical and horizontal delta filter and color decorrelation
// combinational; uses rgbadp_pkg for widths and pos_info_t
`default_nettype none

module rgbadp_filter (
  input  wire logic [rgbadp_pkg::PIX_W-1:0] pix,
  input  wire logic [rgbadp_pkg::PIX_W-1:0] up,
  input  wire logic [rgbadp_pkg::PIX_W-1:0] left,
  input  rgbadp_pkg::pos_info_t             info,
  output logic      [rgbadp_pkg::PIX_W-1:0] diff,
  output logic      [rgbadp_pkg::CH_W-1:0]  blue_minus_green,
  output logic      [rgbadp_pkg::CH_W-1:0]  green_delta,
  output logic      [rgbadp_pkg::CH_W-1:0]  red_minus_green,
  output logic      [rgbadp_pkg::CH_W-1:0]  alpha_delta
);

  localparam int CH_W = rgbadp_pkg::CH_W;

  logic [rgbadp_pkg::PIX_W-1:0] val;

  // byte lanes: B, G, R, A from low to high
  always_comb begin
    for (int c = 0; c < rgbadp_pkg::NCH; c++) begin
      // difference to the pixel above, none on the first row
      diff[c*CH_W +: CH_W] = info.first_row ? pix[c*CH_W +: CH_W]
                           : (pix[c*CH_W +: CH_W] - up[c*CH_W +: CH_W]);
      // difference to the previous delta of the row
      val[c*CH_W +: CH_W]  = info.first_col ? diff[c*CH_W +: CH_W]
                           : (diff[c*CH_W +: CH_W] - left[c*CH_W +: CH_W]);
    end
  end

  // color decorrelation against green
  assign green_delta      = val[1*CH_W +: CH_W];
  assign alpha_delta      = val[3*CH_W +: CH_W];
  assign blue_minus_green = val[0*CH_W +: CH_W] - val[1*CH_W +: CH_W];
  assign red_minus_green  = val[2*CH_W +: CH_W] - val[1*CH_W +: CH_W];

endmodule

`default_nettype wire

[design/rgba_delta_decorrelation_prefilter.sv]
// rgba delta decorrelation prefilter, top level
// data path: each pixel is registered in the filter stage, then in the output register
// throughput: one pixel per clock while out_stall is low, set by the line memory's one read and one write
//   port per cycle; a same-entry read and write is served by bypass
// reset: counters and left deltas cleared, both size registers set to 1; the line
//   memory is not cleared and needs no clearing pass
`default_nettype none

module rgba_delta_decorrelation_prefilter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int BLOCK_ROWS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // pixel input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rgbadp_pkg::CH_W-1:0]   in_blue,
  input  wire logic [rgbadp_pkg::CH_W-1:0]   in_green,
  input  wire logic [rgbadp_pkg::CH_W-1:0]   in_red,
  input  wire logic [rgbadp_pkg::CH_W-1:0]   in_alpha,
  input  wire logic                          in_frame_start,
  // filtered output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [rgbadp_pkg::CH_W-1:0]   out_blue_minus_green,
  output logic      [rgbadp_pkg::CH_W-1:0]   out_green_delta,
  output logic      [rgbadp_pkg::CH_W-1:0]   out_red_minus_green,
  output logic      [rgbadp_pkg::CH_W-1:0]   out_alpha_delta,
  output logic                               out_last_in_line,
  output logic                               out_last_in_block,
  output logic                               out_last_in_image,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rgbadp_pkg::APB_AW-1:0] paddr,
  input  wire logic [rgbadp_pkg::APB_DW-1:0] pwdata,
  output logic      [rgbadp_pkg::APB_DW-1:0] prdata,
  output logic                               pready
);

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PIX_W = rgbadp_pkg::PIX_W;
  localparam int CH_W  = rgbadp_pkg::CH_W;

  logic [rgbadp_pkg::IMG_W_W-1:0] image_width_r;
  logic [rgbadp_pkg::IMG_H_W-1:0] image_height_r;

  logic                  accept;
  logic                  s1_adv;
  logic [AW-1:0]         rd_addr;
  rgbadp_pkg::pos_info_t pos_info;

  logic                  s1_valid_r;
  logic [PIX_W-1:0]      s1_pix_r;
  logic [AW-1:0]         s1_addr_r;
  rgbadp_pkg::pos_info_t s1_info_r;

  logic [PIX_W-1:0]      left_r, left_nxt;
  logic [PIX_W-1:0]      up_data;
  logic [PIX_W-1:0]      diff;
  logic                  mem_wr;

  logic [CH_W-1:0]       f_bmg, f_g, f_rmg, f_a;
  logic                  out_valid_r, out_valid_nxt;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= rgbadp_pkg::IMG_W_W'(1);
      image_height_r <= rgbadp_pkg::IMG_H_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        rgbadp_pkg::REG_IMAGE_WIDTH:
          image_width_r  <= pwdata[rgbadp_pkg::IMG_W_W-1:0];
        rgbadp_pkg::REG_IMAGE_HEIGHT:
          image_height_r <= pwdata[rgbadp_pkg::IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rgbadp_pkg::REG_IMAGE_WIDTH:  prdata = rgbadp_pkg::APB_DW'(image_width_r);
      rgbadp_pkg::REG_IMAGE_HEIGHT: prdata = rgbadp_pkg::APB_DW'(image_height_r);
      default:                      prdata = '0;
    endcase
  end

  // handshake: the filter stage moves on when the output register is free or drains
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign mem_wr   = s1_valid_r && s1_adv;

  // position and line memory address
  rgbadp_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .BLOCK_ROWS (BLOCK_ROWS)
  ) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .frame_start  (in_frame_start),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .rd_addr      (rd_addr),
    .info         (pos_info)
  );

  // previous row, read on transfer, written back when the filter stage moves on
  rgbadp_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr_en   (mem_wr),
    .wr_addr (s1_addr_r),
    .wr_data (s1_pix_r),
    .rd_data (up_data)
  );

  // filter stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= {in_alpha, in_red, in_green, in_blue};
      s1_addr_r <= rd_addr;
      s1_info_r <= pos_info;
    end
  end

  rgbadp_filter u_filter (
    .pix              (s1_pix_r),
    .up               (up_data),
    .left             (left_r),
    .info             (s1_info_r),
    .diff             (diff),
    .blue_minus_green (f_bmg),
    .green_delta      (f_g),
    .red_minus_green  (f_rmg),
    .alpha_delta      (f_a)
  );

  // previous vertical deltas of the row, cleared at each row end
  assign left_nxt = s1_info_r.eol ? '0 : diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (mem_wr) begin
      left_r <= left_nxt;
    end
  end

  // output register
  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      out_blue_minus_green <= f_bmg;
      out_green_delta      <= f_g;
      out_red_minus_green  <= f_rmg;
      out_alpha_delta      <= f_a;
      out_last_in_line     <= s1_info_r.eol;
      out_last_in_block    <= s1_info_r.eob;
      out_last_in_image    <= s1_info_r.eoi;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[tb/tb_rgba_delta_decorrelation_prefilter.sv]
// testbench for the rgba delta decorrelation prefilter: directed and random pixel streams,
// each filtered pixel checked against a behavioral filter kept alongside the stream
// depends on rgbadp_pkg and the rgba_delta_decorrelation_prefilter top level
`default_nettype none

module tb_rgba_delta_decorrelation_prefilter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_W    = rgbadp_pkg::CH_W;
  localparam int NCH     = rgbadp_pkg::NCH;
  localparam int PIX_W   = rgbadp_pkg::PIX_W;
  localparam int IMG_W_W = rgbadp_pkg::IMG_W_W;
  localparam int IMG_H_W = rgbadp_pkg::IMG_H_W;
  localparam int APB_AW  = rgbadp_pkg::APB_AW;
  localparam int APB_DW  = rgbadp_pkg::APB_DW;

  localparam int LINE_DEPTH     = 4096;
  localparam int ROWS_PER_BLOCK = 4;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_PIXELS  = 820;
  localparam int WIDE_PIXELS    = 300;
  localparam int HOLD_QUEUE     = 200;
  localparam int LONG_HOLD      = 600;

  typedef struct {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] alpha;
    logic            frame_start;
  } pixel_t;

  typedef struct {
    logic [CH_W-1:0] blue_minus_green;
    logic [CH_W-1:0] green_delta;
    logic [CH_W-1:0] red_minus_green;
    logic [CH_W-1:0] alpha_delta;
    logic            last_in_line;
    logic            last_in_block;
    logic            last_in_image;
  } filtered_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  // dut ports
  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CH_W-1:0]     in_blue = '0;
  logic [CH_W-1:0]     in_green = '0;
  logic [CH_W-1:0]     in_red = '0;
  logic [CH_W-1:0]     in_alpha = '0;
  logic                in_frame_start = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CH_W-1:0]     out_blue_minus_green;
  logic [CH_W-1:0]     out_green_delta;
  logic [CH_W-1:0]     out_red_minus_green;
  logic [CH_W-1:0]     out_alpha_delta;
  logic                out_last_in_line;
  logic                out_last_in_block;
  logic                out_last_in_image;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // stimulus and expectation stores
  pixel_t      pixel_queue[$];
  filtered_t   filtered_expect[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // filter state as the block should hold it
  logic [IMG_W_W-1:0] width_reg = IMG_W_W'(1);
  logic [IMG_H_W-1:0] height_reg = IMG_H_W'(1);
  logic [PIX_W-1:0]   upper_line [LINE_DEPTH];
  logic [PIX_W-1:0]   left_deltas = '0;
  int unsigned        col_count = 0;
  int unsigned        row_count = 0;

  // sender and receiver pacing
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  rgba_delta_decorrelation_prefilter u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_blue              (in_blue),
    .in_green             (in_green),
    .in_red               (in_red),
    .in_alpha             (in_alpha),
    .in_frame_start       (in_frame_start),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_blue_minus_green (out_blue_minus_green),
    .out_green_delta      (out_green_delta),
    .out_red_minus_green  (out_red_minus_green),
    .out_alpha_delta      (out_alpha_delta),
    .out_last_in_line     (out_last_in_line),
    .out_last_in_block    (out_last_in_block),
    .out_last_in_image    (out_last_in_image),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sizes as the block uses them
  function automatic int unsigned width_in_use(input logic [IMG_W_W-1:0] w);
    if (w == 0) return 1;
    if (w > LINE_DEPTH) return LINE_DEPTH;
    return 32'(w);
  endfunction

  function automatic int unsigned height_in_use(input logic [IMG_H_W-1:0] h);
    return (h == 0) ? 1 : 32'(h);
  endfunction

  // row and column deltas plus color decorrelation for one taken pixel
  task automatic filter_pixel(input pixel_t px);
    int unsigned     w, h, col;
    logic [CH_W-1:0] pix [NCH];
    logic [CH_W-1:0] diff [NCH];
    logic [CH_W-1:0] val [NCH];
    logic [CH_W-1:0] prev;
    logic [PIX_W-1:0] pix_word, new_left;
    logic            eol, eob, eoi;
    filtered_t       r;
    w = width_in_use(width_reg);
    h = height_in_use(height_reg);
    if (px.frame_start) begin
      col_count = 0;
      row_count = 0;
    end
    // a column past a shrunk width ends its row here
    if (col_count >= w) col_count = w - 1;
    col = col_count % LINE_DEPTH;
    pix[0] = px.blue;
    pix[1] = px.green;
    pix[2] = px.red;
    pix[3] = px.alpha;
    for (int c = 0; c < NCH; c++) begin
      prev = (col_count == 0) ? '0 : left_deltas[c*CH_W +: CH_W];
      diff[c] = (row_count == 0) ? pix[c] : pix[c] - upper_line[col][c*CH_W +: CH_W];
      val[c] = diff[c] - prev;
      new_left[c*CH_W +: CH_W] = diff[c];
      pix_word[c*CH_W +: CH_W] = pix[c];
    end
    upper_line[col] = pix_word;
    left_deltas = new_left;
    eol = (col_count + 1 >= w);
    eoi = eol && (row_count + 1 >= h);
    eob = eol && (eoi || ((row_count + 1) % ROWS_PER_BLOCK) == 0);
    r.blue_minus_green = val[0] - val[1];
    r.green_delta      = val[1];
    r.red_minus_green  = val[2] - val[1];
    r.alpha_delta      = val[3];
    r.last_in_line     = eol;
    r.last_in_block    = eob;
    r.last_in_image    = eoi;
    filtered_expect.push_back(r);
    // advance position, wrapping at the image end
    if (eol) begin
      col_count = 0;
      left_deltas = '0;
      row_count = eoi ? 0 : (row_count + 1) & 32'hFFFF;
    end else begin
      col_count++;
    end
  endtask

  task automatic check_field(input string name, input logic [CH_W-1:0] exp_v,
                             input logic [CH_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // sender: offers queued pixels in bursts, holds a payload until its transfer
  always @(posedge clk) begin
    pixel_t taken;
    pixel_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken.blue = in_blue;
        taken.green = in_green;
        taken.red = in_red;
        taken.alpha = in_alpha;
        taken.frame_start = in_frame_start;
        filter_pixel(taken);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pixel_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          nxt = pixel_queue.pop_front();
          in_valid <= 1'b1;
          in_blue <= nxt.blue;
          in_green <= nxt.green;
          in_red <= nxt.red;
          in_alpha <= nxt.alpha;
          in_frame_start <= nxt.frame_start;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off while the wide image is queued
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && pixel_queue.size() > HOLD_QUEUE) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall <= (mode_left % 3 == 0);
        default:        out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result checker: every transfer against the oldest expectation
  always @(posedge clk) begin
    filtered_t exp_r;
    if (rst_n && out_valid !== 1'b0 && !out_stall) begin
      if (filtered_expect.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual bmg %0h g %0h rmg %0h a %0h",
                 $time, out_blue_minus_green, out_green_delta, out_red_minus_green,
                 out_alpha_delta);
        mismatches++;
      end else begin
        exp_r = filtered_expect.pop_front();
        check_field("blue_minus_green", exp_r.blue_minus_green, out_blue_minus_green);
        check_field("green_delta", exp_r.green_delta, out_green_delta);
        check_field("red_minus_green", exp_r.red_minus_green, out_red_minus_green);
        check_field("alpha_delta", exp_r.alpha_delta, out_alpha_delta);
        check_field("last_in_line", exp_r.last_in_line, out_last_in_line);
        check_field("last_in_block", exp_r.last_in_block, out_last_in_block);
        check_field("last_in_image", exp_r.last_in_image, out_last_in_image);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // register write followed by a read back of the same register
  task automatic write_register(input logic reg_sel, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] expected_read;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == rgbadp_pkg::REG_IMAGE_WIDTH) begin
      width_reg = value[IMG_W_W-1:0];
      expected_read = APB_DW'(width_reg);
    end else begin
      height_reg = value[IMG_H_W-1:0];
      expected_read = APB_DW'(height_reg);
    end
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== expected_read) begin
      $display("%0t: register %0d read mismatch, expected %0h, actual %0h",
               $time, reg_sel, expected_read, prdata);
      mismatches++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // waits until every queued pixel is taken and every result is back
  task automatic wait_idle;
    while (pixel_queue.size() != 0 || in_valid || filtered_expect.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_size(input logic [APB_DW-1:0] w, input logic [APB_DW-1:0] h);
    wait_idle();
    write_register(rgbadp_pkg::REG_IMAGE_WIDTH, w);
    write_register(rgbadp_pkg::REG_IMAGE_HEIGHT, h);
    @(negedge clk);
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] bgra, input logic fs);
    pixel_t p;
    p.blue = bgra[7:0];
    p.green = bgra[15:8];
    p.red = bgra[23:16];
    p.alpha = bgra[31:24];
    p.frame_start = fs;
    pixel_queue.push_back(p);
  endtask

  initial begin
    int unsigned old_w, new_w, new_h, n_pix, area, phase, random_pixels;
    bit          fresh;
    int unsigned pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset size 1x1: each pixel is a whole image, later ones rely on the wrap
    push_pixel(32'h0000_0000, 1'b1);
    push_pixel(32'hFFFF_FFFF, 1'b0);
    push_pixel(32'h00FF_00FF, 1'b0);
    push_pixel(32'hFF00_FF00, 1'b1);

    // 2x5: one full block of rows then a block cut at the image height
    set_size(2, 5);
    push_pixel(32'h0000_0000, 1'b1);
    for (int i = 1; i < 10; i++)
      push_pixel((i % 3 == 0) ? $urandom : ((i % 3 == 1) ? 32'hFFFF_FFFF : 32'h0000_0000),
                 1'b0);

    // wrap into a new image, restart it mid-row, stop in the middle of row one
    push_pixel(32'hFF01_80FE, 1'b0);
    push_pixel(32'h01FF_7F02, 1'b0);
    push_pixel(32'hFFFF_FFFF, 1'b0);
    push_pixel(32'h8080_8080, 1'b1);
    push_pixel(32'h0000_0000, 1'b0);
    push_pixel(32'hFFFF_FFFF, 1'b0);

    // shrink mid-image: the pending column and row are past the new size
    set_size(1, 0);
    push_pixel(32'h7F7F_7F7F, 1'b0);
    push_pixel(32'h00FF_FF00, 1'b0);

    // zero width and height act as one
    set_size(0, 0);
    push_pixel(32'hFF00_00FF, 1'b0);
    push_pixel($urandom, 1'b0);

    // random sweep: small images mostly, a few at the largest sizes
    phase = 0;
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      old_w = width_in_use(width_reg);
      case (phase)
        2: begin
          new_w = 8191;
          new_h = 2;
          n_pix = WIDE_PIXELS;
        end
        5: begin
          new_w = 2;
          new_h = 65535;
          n_pix = 40;
        end
        default: begin
          pick = $urandom_range(0, 19);
          if (pick < 14) new_w = $urandom_range(1, 8);
          else if (pick < 19) new_w = $urandom_range(9, 40);
          else new_w = $urandom_range(0, 1) ? 0 : $urandom_range(LINE_DEPTH + 1, 8191);
          new_h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 65535) : $urandom_range(0, 6);
          area = width_in_use(IMG_W_W'(new_w)) * height_in_use(IMG_H_W'(new_h));
          if (area <= 30)
            n_pix = area * $urandom_range(1, 2)
                    + $urandom_range(0, width_in_use(IMG_W_W'(new_w)));
          else
            n_pix = $urandom_range(20, 60);
        end
      endcase
      random_pixels += n_pix;
      set_size(new_w, new_h);
      // a wider line needs a fresh image so no unwritten column is read from above
      fresh = (width_in_use(IMG_W_W'(new_w)) > old_w) || ($urandom_range(0, 3) != 0);
      for (int i = 0; i < n_pix; i++)
        push_pixel($urandom, (i == 0 && fresh) || ($urandom_range(0, 49) == 0));
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
design/rgbadp_pkg.sv
design/rgbadp_line_mem.sv
design/rgbadp_pos.sv
design/rgbadp_filter.sv
design/rgba_delta_decorrelation_prefilter.sv
tb/tb_rgba_delta_decorrelation_prefilter.sv
